// File: rtl/modexp_pkg.sv
package modexp_pkg;

    // Datapath width; registers, base and the exponent scan follow it
    localparam int OPERAND_WIDTH = 32;
    localparam int FIELD_W       = 32;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH);
    localparam int CFG_IDX_W     = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(1);

    // Controller states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_PREP   = 5'b00100,
        ST_MUL    = 5'b01000,
        ST_COMMIT = 5'b10000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_base;
        logic reduce_step;
        logic prep;
        logic mul_step;
        logic commit;
        logic out_load;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic count_last;
        logic exp_last;
        logic out_free;
    } status_t;

endpackage

// File: rtl/modexp_ctrl.sv
module modexp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  modexp_pkg::status_t status,
    output modexp_pkg::cmd_t    cmd
);
    import modexp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   pending_reg;
    logic   pending_next;

    assign s_tready = (state_reg == ST_IDLE) && !pending_reg;

    // Sequence one word: reduce base, then one multiply pass per exponent bit
    always_comb begin
        state_next   = state_reg;
        pending_next = pending_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                // hand the finished result to the output register first
                if (pending_reg) begin
                    if (status.out_free) begin
                        cmd.out_load = 1'b1;
                        pending_next = 1'b0;
                    end
                end else if (s_tvalid) begin
                    cmd.load_base = 1'b1;
                    state_next    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                cmd.reduce_step = 1'b1;
                if (status.count_last) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (status.count_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                if (status.exp_last) begin
                    state_next   = ST_IDLE;
                    pending_next = 1'b1;
                end else begin
                    state_next = ST_MUL;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// File: rtl/modexp_dp.sv
module modexp_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [modexp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [modexp_pkg::FIELD_W-1:0]         cfg_data,
    input  logic [modexp_pkg::FIELD_W-1:0]         base_in,
    input  modexp_pkg::cmd_t                       cmd,
    output modexp_pkg::status_t                    status,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [modexp_pkg::FIELD_W-1:0]         m_tdata
);
    import modexp_pkg::*;

    localparam int OPW = OPERAND_WIDTH;

    // (2*acc + (bit ? a : 0)) mod m, for acc, a < m; sum stays below 3m
    function automatic logic [OPW-1:0] dbl_add_mod(
        input logic [OPW-1:0] acc,
        input logic [OPW-1:0] a,
        input logic           bit_i,
        input logic [OPW-1:0] m
    );
        logic [OPW+2:0] t;
        logic [OPW+2:0] d1;
        logic [OPW+2:0] d2;
        t  = {2'b00, acc, 1'b0} + (bit_i ? {3'b000, a} : '0);
        d1 = t - {3'b000, m};
        d2 = t - {2'b00, m, 1'b0};
        if (!d2[OPW+2]) begin
            return d2[OPW-1:0];
        end else if (!d1[OPW+2]) begin
            return d1[OPW-1:0];
        end
        return t[OPW-1:0];
    endfunction

    logic [OPW-1:0]     mod_reg;
    logic [OPW-1:0]     exp_reg;
    logic [OPW-1:0]     base_sh_reg;
    logic [OPW-1:0]     rem_reg;
    logic [OPW-1:0]     sq_reg;
    logic [OPW-1:0]     res_reg;
    logic [OPW-1:0]     scan_reg;
    logic [OPW-1:0]     acc_r_reg;
    logic [OPW-1:0]     acc_b_reg;
    logic [OPW-1:0]     exp_sh_reg;
    logic [CNT_W-1:0]   bit_cnt_reg;
    logic [CNT_W-1:0]   exp_cnt_reg;
    logic               m_tvalid_reg;
    logic [FIELD_W-1:0] m_tdata_reg;

    logic [OPW:0]       red_t;
    logic [OPW+1:0]     red_d;
    logic [OPW-1:0]     rem_next;

    // One restoring-division step of the base by the modulus
    always_comb begin
        red_t    = {rem_reg, base_sh_reg[OPW-1]};
        red_d    = {1'b0, red_t} - {2'b00, mod_reg};
        rem_next = red_d[OPW+1] ? red_t[OPW-1:0] : red_d[OPW-1:0];
    end

    assign status.count_last = (bit_cnt_reg == CNT_W'(OPW - 1));
    assign status.exp_last   = (exp_cnt_reg == CNT_W'(OPW - 1));
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= OPW'(1);
            exp_reg <= OPW'(1);
        end else if (cfg_we) begin
            if (cfg_index == REG_MODULUS) begin
                mod_reg <= OPW'(cfg_data);
            end else if (cfg_index == REG_EXPONENT) begin
                exp_reg <= OPW'(cfg_data);
            end
        end
    end

    // Bit counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg <= '0;
            exp_cnt_reg <= '0;
        end else begin
            if (cmd.load_base || cmd.prep || cmd.commit) begin
                bit_cnt_reg <= '0;
            end else if (cmd.reduce_step || cmd.mul_step) begin
                bit_cnt_reg <= bit_cnt_reg + CNT_W'(1);
            end
            if (cmd.prep) begin
                exp_cnt_reg <= '0;
            end else if (cmd.commit) begin
                exp_cnt_reg <= exp_cnt_reg + CNT_W'(1);
            end
        end
    end

    // Arithmetic registers: square and conditional multiply share the scan of b
    always_ff @(posedge aclk) begin
        if (cmd.load_base) begin
            base_sh_reg <= OPW'(base_in);
            rem_reg     <= '0;
        end
        if (cmd.reduce_step) begin
            base_sh_reg <= base_sh_reg << 1;
            rem_reg     <= rem_next;
        end
        if (cmd.prep) begin
            sq_reg     <= rem_reg;
            scan_reg   <= rem_reg;
            res_reg    <= (mod_reg == OPW'(1)) ? '0 : OPW'(1);
            acc_r_reg  <= '0;
            acc_b_reg  <= '0;
            exp_sh_reg <= exp_reg;
        end
        if (cmd.mul_step) begin
            acc_r_reg <= dbl_add_mod(acc_r_reg, res_reg, scan_reg[OPW-1], mod_reg);
            acc_b_reg <= dbl_add_mod(acc_b_reg, sq_reg, scan_reg[OPW-1], mod_reg);
            scan_reg  <= scan_reg << 1;
        end
        if (cmd.commit) begin
            sq_reg     <= acc_b_reg;
            scan_reg   <= acc_b_reg;
            acc_r_reg  <= '0;
            acc_b_reg  <= '0;
            exp_sh_reg <= exp_sh_reg >> 1;
            if (exp_sh_reg[0]) begin
                res_reg <= acc_r_reg;
            end
        end
    end

    // Output register; a zero modulus answers zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= (mod_reg == '0) ? '0 : FIELD_W'(res_reg);
        end
    end

endmodule

// File: rtl/modular_exponentiation.sv
// Channel   Direction  Ports                                  Contents
// s_        in         s_tvalid, s_tready, s_tdata[31:0]      base_value
// m_        out        m_tvalid, m_tready, m_tdata[31:0]      power_result
// cfg_      in         cfg_valid, cfg_ready, cfg_index, cfg_data   0 modulus, 1 exponent
//
// Each word passes base reduction, then the bit-serial modular multiplier runs one
// multiply pass per exponent bit, each pass ending in a commit.
// The base is first reduced by a restoring division, one step per base bit.
// aresetn is synchronous, active low; modulus and exponent reset to 1.
// A result held by m_tready low is kept in the output register; a new base is
// taken once the previous result has moved into that register.
module modular_exponentiation (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [modexp_pkg::FIELD_W-1:0]      s_tdata,   // [31:0] base_value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [modexp_pkg::FIELD_W-1:0]      m_tdata,   // [31:0] power_result
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [modexp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [modexp_pkg::FIELD_W-1:0]      cfg_data
);
    import modexp_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Configuration must only be written while idle; the block does not enforce it, so always take it
    assign cfg_ready = 1'b1;

    modexp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    modexp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .base_in   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: tb/sv/tb_modular_exponentiation.sv
`timescale 1ns / 1ps

module tb_modular_exponentiation;
    import modexp_pkg::*;

    // One word: reduce, prep, then a multiply pass and a commit per exponent bit
    localparam int WORD_LATENCY   = 1091;
    localparam int HOLDOFF_CYCLES = 4000;
    localparam int QUIET_LIMIT    = 30000;
    localparam int TARGET_BASES   = 140;
    localparam int CALM_FROM      = 120;
    localparam int PROBE_ROWS     = 21;

    // Indexes that map to no register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    typedef logic [FIELD_W-1:0] word_t;

    typedef struct packed {
        word_t modulus;
        word_t exponent;
        logic  spare_writes;
        word_t base;
        logic  typed;
        word_t want;
    } probe_row_t;

    logic  aclk;
    logic  aresetn;
    logic  s_tvalid;
    logic  s_tready;
    word_t s_tdata;
    logic  m_tvalid;
    logic  m_tready;
    word_t m_tdata;
    logic  cfg_valid;
    logic  cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    word_t cfg_data;

    // Shadow of the key registers, updated on each accepted write
    word_t key_modulus;
    word_t key_exponent;

    word_t expected_powers [$];
    probe_row_t probe_table [PROBE_ROWS];

    int  mismatches;
    int  bases_sent;
    int  results_checked;
    int  key_writes;
    int  key_phases;
    int  quiet_cycles;
    bit  calm;
    bit  holdoff_wanted;
    bit  holdoff_done;

    modular_exponentiation dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Right-to-left square and multiply; 64-bit products cannot overflow
    function automatic word_t power_mod(input word_t base, input word_t expo, input word_t n);
        logic [2*FIELD_W-1:0] acc;
        logic [2*FIELD_W-1:0] sq;
        if (n == '0) begin
            return '0;
        end
        acc = (n == word_t'(1)) ? '0 : 1;
        sq  = base % n;
        for (int i = 0; i < OPERAND_WIDTH; i++) begin
            if (expo[i]) begin
                acc = (acc * sq) % n;
            end
            sq = (sq * sq) % n;
        end
        return acc[FIELD_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("[%0t] %s: got %08h, want %08h", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one base; leave tvalid high so back-to-back words need no toggle
    task automatic send_base(input word_t base, input bit typed, input word_t want);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= base;
        do @(posedge aclk); while (!s_tready);
        expected_powers.push_back(typed ? want : power_mod(base, key_exponent, key_modulus));
        bases_sent++;
    endtask

    // Hold cfg_valid high across back-to-back writes; caller lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        key_writes++;
        case (idx)
            REG_MODULUS: begin
                key_modulus = value;
            end
            REG_EXPONENT: begin
                key_exponent = value;
            end
            default: begin
            end
        endcase
    endtask

    // Stop offering, let every pending result drain, then load a new key
    task automatic load_key(input word_t n, input word_t expo, input bit spare_writes);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_powers.size() != 0);
        write_reg(REG_MODULUS, n);
        write_reg(REG_EXPONENT, expo);
        if (spare_writes) begin
            write_reg(REG_SPARE_2, '0);
            write_reg(REG_SPARE_3, $urandom);
        end
        cfg_valid <= 1'b0;
        key_phases++;
    endtask

    function automatic word_t pick_modulus();
        case ($urandom_range(0, 9))
            0: return word_t'(1);
            1: return '1;
            2: return word_t'(2);
            3: return $urandom_range(2, 255);
            4: return 32'h8000_0000 | $urandom;
            5: return $urandom_range(3, 65535);
            6: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic word_t pick_exponent();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return word_t'(1);
            2: return '1;
            3: return $urandom_range(2, 64);
            default: return $urandom;
        endcase
    endfunction

    function automatic word_t pick_base(input word_t n);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 15);
            3: return (n != '0) ? $urandom % n : $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: check each word, idle in bursts, one long hold-off on request
    initial begin
        int gap_left;
        int hold_left;
        word_t want;
        gap_left  = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (m_tvalid && m_tready) begin
                if (expected_powers.size() == 0) begin
                    report_mismatch("power_result with nothing pending", m_tdata, '0);
                end else begin
                    want = expected_powers.pop_front();
                    if (m_tdata !== want) begin
                        report_mismatch("power_result", m_tdata, want);
                    end
                    results_checked++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (holdoff_wanted && !holdoff_done) begin
                holdoff_done = 1'b1;
                hold_left    = HOLDOFF_CYCLES - 1;
                m_tready     <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(1, 11) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    // Watchdog: end the run if no channel moves a word for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase_len;
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        key_modulus     = word_t'(1);
        key_exponent    = word_t'(1);
        mismatches      = 0;
        bases_sent      = 0;
        results_checked = 0;
        key_writes      = 0;
        key_phases      = 0;
        quiet_cycles    = 0;
        calm            = 1'b0;
        holdoff_wanted  = 1'b0;
        holdoff_done    = 1'b0;

        // modulus, exponent, spare writes, base, typed, want
        probe_table = '{
            // reset key: modulus one, so every result is zero
            '{32'h0000_0001, 32'h0000_0001, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'h0},
            '{32'h0000_0001, 32'h0000_0001, 1'b0, 32'h0000_0000, 1'b1, 32'h0},
            // zero exponent gives one
            '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b1, 32'h1},
            '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'h1},
            // zero exponent with modulus one gives zero
            '{32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0000_0005, 1'b1, 32'h0},
            // exponent one is plain reduction
            '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'h0},
            '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0002, 1'b0, 32'h0},
            // largest 32-bit prime, exponent p-1 and all ones
            '{32'hFFFF_FFFB, 32'hFFFF_FFFA, 1'b0, 32'h0000_3039, 1'b0, 32'h0},
            '{32'hFFFF_FFFB, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0},
            // zero modulus answers zero
            '{32'h0000_0000, 32'h0000_0005, 1'b0, 32'h0000_0007, 1'b1, 32'h0},
            '{32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b1, 32'h0},
            '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'h0},
            // writes to unused indexes must leave the key alone: 5^2 mod 13
            '{32'h0000_000D, 32'h0000_0002, 1'b1, 32'h0000_0005, 1'b1, 32'hC},
            '{32'h0000_0002, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'h1},
            '{32'h8000_0000, 32'h0000_001E, 1'b0, 32'h0000_0002, 1'b1, 32'h4000_0000},
            '{32'h8000_0000, 32'h0000_0020, 1'b0, 32'h0000_0002, 1'b1, 32'h0},
            '{32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'h0000_0003, 1'b0, 32'h0},
            '{32'h3B9A_CA07, 32'h0001_0001, 1'b0, 32'hDEAD_BEEF, 1'b0, 32'h0},
            '{32'h3B9A_CA07, 32'h0001_0001, 1'b0, 32'h0000_0000, 1'b1, 32'h0},
            '{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'h1234_5678, 1'b1, 32'h0}
        };

        // Hold reset, then release it at an edge
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: walk the table, reloading the key where a row changes it
        foreach (probe_table[i]) begin
            if (probe_table[i].modulus != key_modulus
                    || probe_table[i].exponent != key_exponent
                    || probe_table[i].spare_writes) begin
                load_key(probe_table[i].modulus, probe_table[i].exponent,
                         probe_table[i].spare_writes);
            end
            send_base(probe_table[i].base, probe_table[i].typed, probe_table[i].want);
        end

        // Random: new key per phase, first phase runs under a long receiver hold-off
        while (bases_sent < TARGET_BASES) begin
            load_key(pick_modulus(), pick_exponent(), $urandom_range(0, 3) == 0);
            if (key_phases == 1 + 0 || !holdoff_wanted) begin
                holdoff_wanted = 1'b1;
            end
            phase_len = $urandom_range(6, 14);
            for (int k = 0; k < phase_len && bases_sent < TARGET_BASES; k++) begin
                if (bases_sent >= CALM_FROM) begin
                    calm = 1'b1;
                end
                send_base(pick_base(key_modulus), 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then allow one word time for anything stray
        while (expected_powers.size() != 0) @(posedge aclk);
        repeat (WORD_LATENCY + 100) @(posedge aclk);

        $display("%0d bases under %0d keys (%0d register writes), %0d results checked",
                 bases_sent, key_phases, key_writes, results_checked);
        $display("zero/one/max modulus and exponent, unused indexes, %0d-cycle output stall",
                 HOLDOFF_CYCLES);
        if (mismatches == 0 && expected_powers.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_powers.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
